// ===== rtl/core/aes_counter_mode_byte_generator_top_assert.svh =====
// Assertion macros for the counter-mode byte generator.
`ifndef AES_COUNTER_MODE_BYTE_GENERATOR_TOP_ASSERT_SVH
`define AES_COUNTER_MODE_BYTE_GENERATOR_TOP_ASSERT_SVH

// Implication checked on the cycle itself.
`define CTRDRBG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CTRDRBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ctrdrbg_pkg.sv =====
// Shared types, AES tables and round functions for the counter-mode byte generator.
package ctrdrbg_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int POS_W       = $clog2(BLOCK_BYTES) + 1;
  localparam int BLK_W       = BLOCK_BYTES * 8;
  localparam int LAST_ROUND  = 10;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_WORD    = 2'd1,
    OP_RUN     = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic {
    REG_SEED_LOW  = 1'b0,
    REG_SEED_HIGH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       load_key;
    logic       enc_start;
    logic       enc_round;
    logic [3:0] round_idx;
    logic       take;
    logic       clr_acc;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    case (idx)
      4'd1:    return 8'h01;
      4'd2:    return 8'h02;
      4'd3:    return 8'h04;
      4'd4:    return 8'h08;
      4'd5:    return 8'h10;
      4'd6:    return 8'h20;
      4'd7:    return 8'h40;
      4'd8:    return 8'h80;
      4'd9:    return 8'h1b;
      4'd10:   return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key from the previous one; word c sits in bits [32c +: 32]
  function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
          SBOX[k[111:104]] ^ rc};
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns; byte i at [8i +: 8]
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic last);
    logic [BLK_W-1:0] t;
    logic [BLK_W-1:0] r;
    logic [BLK_W-1:0] m;
    logic [7:0] a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = SBOX[s[8*i +: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        r[8*(i+4*c) +: 8] = t[8*(i + 4*((c+i) % 4)) +: 8];
    for (int c = 0; c < 4; c++) begin
      a0  = r[8*(4*c)   +: 8];
      a1  = r[8*(4*c+1) +: 8];
      a2  = r[8*(4*c+2) +: 8];
      a3  = r[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return last ? r : m;
  endfunction

endpackage

// ===== rtl/core/aes_counter_mode_byte_generator_top.sv =====
// Top level of the AES-128 counter-mode pseudorandom byte generator.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | in        | in_valid / in_stall   | in_op, in_byte_count
//  out_    | out       | out_valid / out_stall | out_value_low, out_value_high
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. Each keystream refill runs in the single iterated
// round unit (counter load plus ten rounds, key schedule on the fly).
// Byte and word ops refill first if the buffer is short; a run of n bytes
// refills as needed (at most two refills); restart: one refill, no item out.
// The result is held until out_stall is low. cfg_ready is always high.
module aes_counter_mode_byte_generator_top import ctrdrbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value_low,
  output logic [63:0] out_value_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

`include "aes_counter_mode_byte_generator_top_assert.svh"

  cmd_t             cmd;
  sts_t             sts;
  logic [BLK_W-1:0] acc;

  assign cfg_ready = 1'b1;

  ctrdrbg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_byte_count (in_byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  ctrdrbg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .acc       (acc)
  );

  assign out_value_low  = acc[63:0];
  assign out_value_high = acc[127:64];

  `CTRDRBG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
  `CTRDRBG_ASSERT_NOW(a_one_item, out_valid, in_stall, "input taken while result pending")
  `CTRDRBG_ASSERT_NEXT(a_result_once, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

// ===== rtl/core/ctrdrbg_dp.sv =====
// Datapath: seed, counter, AES round unit, keystream buffer and output assembly.
module ctrdrbg_dp import ctrdrbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [BLK_W-1:0]  acc
);

  logic [63:0]       seed_lo_r, seed_hi_r;
  logic [BLK_W-1:0]  key_r, ctr_r, st_r, rk_r, buf_r, acc_r;
  logic [POS_W-1:0]  pos_r;
  logic [3:0]        kidx_r;
  logic [BLK_W-1:0]  ctr_nxt, rk_nxt, st_nxt;

  assign ctr_nxt = ctr_r + BLK_W'(1);
  assign rk_nxt  = key_step(rk_r, rcon(cmd.round_idx));
  assign st_nxt  = aes_round(st_r, cmd.round_idx == 4'(LAST_ROUND)) ^ rk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_lo_r <= '0;
      seed_hi_r <= '0;
      ctr_r     <= '0;
      buf_r     <= '0;
      acc_r     <= '0;
      kidx_r    <= '0;
      pos_r     <= POS_W'(BLOCK_BYTES);
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SEED_LOW:  seed_lo_r <= cfg_data;
          REG_SEED_HIGH: seed_hi_r <= cfg_data;
          default:       seed_lo_r <= seed_lo_r;
        endcase
      end
      if (cmd.load_key) begin
        key_r <= {seed_hi_r, seed_lo_r};
        ctr_r <= '0;
      end
      if (cmd.enc_start) begin
        ctr_r <= ctr_nxt;
        st_r  <= ctr_nxt ^ key_r;
        rk_r  <= key_r;
      end
      if (cmd.enc_round) begin
        st_r <= st_nxt;
        rk_r <= rk_nxt;
        if (cmd.round_idx == 4'(LAST_ROUND)) begin
          buf_r <= st_nxt;
          pos_r <= '0;
        end
      end
      if (cmd.clr_acc) begin
        acc_r  <= '0;
        kidx_r <= '0;
      end
      if (cmd.take) begin
        acc_r[{kidx_r, 3'b000} +: 8] <= buf_r[{pos_r[3:0], 3'b000} +: 8];
        pos_r  <= pos_r + POS_W'(1);
        kidx_r <= kidx_r + 4'd1;
      end
    end
  end

  assign sts.pos = pos_r;
  assign acc     = acc_r;

endmodule

// ===== rtl/core/ctrdrbg_ctrl.sv =====
// Controller: sequences key load, block encryption, byte takes and result handoff.
module ctrdrbg_ctrl import ctrdrbg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [4:0] in_byte_count,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_ENC_START, S_ENC, S_TAKE, S_DONE
  } state_t;

  state_t   state_r;
  op_t      op_r;
  logic [4:0] rem_r;
  logic [3:0] rnd_r;
  logic       accept;
  logic [4:0] cnt;
  logic       refill_first;
  logic       at_last;

  assign accept = (state_r == S_IDLE) && in_valid;
  assign at_last = sts.pos == POS_W'(BLOCK_BYTES - 1);

  always_comb begin
    case (op_t'(in_op))
      OP_BYTE: cnt = 5'd1;
      OP_WORD: cnt = 5'd4;
      OP_RUN:  cnt = (in_byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : in_byte_count;
      default: cnt = 5'd0;
    endcase
    case (op_t'(in_op))
      OP_WORD: refill_first = sts.pos > POS_W'(BLOCK_BYTES - 4);
      default: refill_first = sts.pos >= POS_W'(BLOCK_BYTES);
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.round_idx = rnd_r;
    case (state_r)
      S_IDLE: begin
        cmd.clr_acc  = accept;
        cmd.load_key = accept && (op_t'(in_op) == OP_RESTART);
      end
      S_ENC_START: cmd.enc_start = 1'b1;
      S_ENC:       cmd.enc_round = 1'b1;
      S_TAKE:      cmd.take      = 1'b1;
      default:     cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_BYTE;
      rem_r   <= '0;
      rnd_r   <= 4'd1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op_t'(in_op);
            rem_r <= cnt;
            if (op_t'(in_op) == OP_RESTART) state_r <= S_ENC_START;
            else if (cnt == 5'd0)           state_r <= S_DONE;
            else if (refill_first)          state_r <= S_ENC_START;
            else                            state_r <= S_TAKE;
          end
        end
        S_ENC_START: begin
          rnd_r   <= 4'd1;
          state_r <= S_ENC;
        end
        S_ENC: begin
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == 4'(LAST_ROUND)) begin
            if (op_r == OP_RESTART) state_r <= S_IDLE;
            else if (rem_r == 5'd0) state_r <= S_DONE;
            else                    state_r <= S_TAKE;
          end
        end
        S_TAKE: begin
          rem_r <= rem_r - 5'd1;
          // a run refills right after the last buffer byte goes out
          if (op_r == OP_RUN && at_last) state_r <= S_ENC_START;
          else if (rem_r == 5'd1)        state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;

endmodule

// ===== tb/sv/aes_counter_mode_byte_generator_top_test.sv =====
// Self-checking testbench for the AES-128 counter-mode byte generator.
`timescale 1ns / 100ps

module aes_counter_mode_byte_generator_top_test;
  import ctrdrbg_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    op_t        op;
    logic [4:0] count;
  } gen_req_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } gen_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [4:0]  in_byte_count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value_low;
  logic [63:0] out_value_high;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  // in_stall seen at the last rising edge tells the driver whether its item left
  logic in_stall_q;
  logic in_took;

  aes_counter_mode_byte_generator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value_low(out_value_low), .out_value_high(out_value_high),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [127:0] key_reg;
  logic [127:0] ctr_val;
  logic [127:0] ks_buf;
  int unsigned  rd_pos;
  logic [127:0] rkeys [11];

  gen_req_t  pending_reqs[$];
  gen_word_t expected_words[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        mismatches;
  int        results_seen;
  int        items_sent;
  longint    cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sb(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic expand_seed();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] t0;
    logic [7:0] rc;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = key_reg[8*i +: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
      if (i % 4 == 0) begin
        t0 = t[0];
        t[0] = sb(t[1]) ^ rc;
        t[1] = sb(t[2]);
        t[2] = sb(t[3]);
        t[3] = sb(t0);
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) rkeys[r][8*i +: 8] = w[16*r+i];
  endtask

  task automatic encrypt_block();
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    for (int i = 0; i < 16; i++) s[i] = ctr_val[8*i +: 8] ^ rkeys[0][8*i +: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) t[i] = sb(s[i]);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) s[i+4*c] = t[i + 4*((c+i) % 4)];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkeys[r][8*i +: 8];
    end
    for (int i = 0; i < 16; i++) ks_buf[8*i +: 8] = s[i];
  endtask

  task automatic refill_keystream();
    ctr_val = ctr_val + 128'd1;
    encrypt_block();
    rd_pos = 0;
  endtask

  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    b = ks_buf[8*(rd_pos % 16) +: 8];
    rd_pos++;
    return b;
  endfunction

  task automatic predict_output(input gen_req_t req);
    logic [127:0] v;
    int unsigned  n;
    v = '0;
    n = req.count;
    case (req.op)
      OP_RESTART: begin
        expand_seed();
        ctr_val = '0;
        refill_keystream();
        return;
      end
      OP_BYTE: begin
        if (rd_pos >= BLOCK_BYTES) refill_keystream();
        v[7:0] = next_byte();
      end
      OP_WORD: begin
        if (rd_pos > BLOCK_BYTES - 4) refill_keystream();
        for (int k = 0; k < 4; k++) v[8*k +: 8] = next_byte();
      end
      default: begin
        if (n > BLOCK_BYTES) n = BLOCK_BYTES;
        if (n > 0 && rd_pos >= BLOCK_BYTES) refill_keystream();
        for (int k = 0; k < n; k++) begin
          v[8*k +: 8] = next_byte();
          if (rd_pos >= BLOCK_BYTES) refill_keystream();
        end
      end
    endcase
    expected_words.push_back('{lo: v[63:0], hi: v[127:64]});
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("error at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_stall_q)) begin
      // current item still stalled: hold it; with none, maybe send the next one
      if (in_valid) begin
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_op         <= pending_reqs[0].op;
        in_byte_count <= pending_reqs[0].count;
        void'(pending_reqs.pop_front());
      end
    end else begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_op         <= pending_reqs[0].op;
        in_byte_count <= pending_reqs[0].count;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    in_took = rst_n && in_valid && !in_stall;
    cycle_count <= cycle_count + 1;
    if (in_took) begin
      predict_output('{op: op_t'(in_op), count: in_byte_count});
      items_sent++;
    end
  end

  // monitor
  always @(posedge clk) begin
    gen_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected item, value_low", out_value_low, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_value_low !== want.lo) report_mismatch("value_low", out_value_low, want.lo);
        if (out_value_high !== want.hi)
          report_mismatch("value_high", out_value_high, want.hi);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d items outstanding", expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_seed(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SEED_LOW) key_reg[63:0] = val;
    else key_reg[127:64] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    // a trailing restart yields nothing; give it time to finish
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_req(input op_t op, input logic [4:0] cnt);
    pending_reqs.push_back('{op: op, count: cnt});
  endtask

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 5'd0;
    if (r < 12) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16, 1));
  endfunction

  task automatic queue_random(input int n);
    int r;
    queue_req(OP_RESTART, 5'($urandom));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) queue_req(OP_BYTE, 5'($urandom));
      else if (r < 55) queue_req(OP_WORD, 5'($urandom));
      else if (r < 95) queue_req(OP_RUN, pick_count());
      else queue_req(OP_RESTART, 5'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = '0; in_byte_count = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_SEED_LOW; cfg_data = '0;
    in_stall_q = 1'b1;
    key_reg = '0; ctr_val = '0; ks_buf = '0; rd_pos = BLOCK_BYTES;
    mismatches = 0; results_seen = 0; items_sent = 0; cycle_count = 0;
    send_idle_pct = 23; recv_idle_pct = 74;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: all-zero key, boundary counts, word drop and run wrap
    write_seed(REG_SEED_LOW, 64'd0);
    write_seed(REG_SEED_HIGH, 64'd0);
    queue_req(OP_RESTART, 5'd0);
    queue_req(OP_BYTE, 5'd31);
    queue_req(OP_RUN, 5'd13);
    queue_req(OP_WORD, 5'd0);
    queue_req(OP_RUN, 5'd0);
    queue_req(OP_RUN, 5'd16);
    queue_req(OP_RUN, 5'd31);
    queue_req(OP_RUN, 5'd17);
    queue_req(OP_RUN, 5'd1);
    queue_req(OP_WORD, 5'd5);
    queue_req(OP_RUN, 5'd14);
    queue_req(OP_BYTE, 5'd0);
    queue_req(OP_WORD, 5'd0);
    queue_req(OP_RESTART, 5'd31);
    queue_req(OP_WORD, 5'd0);
    wait_drained();

    write_seed(REG_SEED_LOW, '1);
    write_seed(REG_SEED_HIGH, '1);
    queue_req(OP_RESTART, 5'd0);
    queue_req(OP_RUN, 5'd16);
    queue_req(OP_BYTE, 5'd0);
    queue_req(OP_RUN, 5'd15);
    queue_req(OP_WORD, 5'd0);
    wait_drained();

    send_idle_pct = 23; recv_idle_pct = 74;
    write_seed(REG_SEED_LOW, {$urandom, $urandom});
    write_seed(REG_SEED_HIGH, {$urandom, $urandom});
    queue_random(130);
    wait_drained();

    send_idle_pct = 74; recv_idle_pct = 23;
    write_seed(REG_SEED_LOW, 64'h0123456789abcdef);
    write_seed(REG_SEED_HIGH, {$urandom, $urandom});
    queue_random(130);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_seed(REG_SEED_LOW, {$urandom, $urandom});
    write_seed(REG_SEED_HIGH, 64'h8000000000000001);
    queue_random(130);
    wait_drained();

    $display("%0d items sent, %0d results checked over five seeds and three idle mixes",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ctrdrbg_pkg.sv
rtl/core/ctrdrbg_dp.sv
rtl/core/ctrdrbg_ctrl.sv
rtl/core/aes_counter_mode_byte_generator_top.sv
tb/sv/aes_counter_mode_byte_generator_top_test.sv
